// ===== rtl/dataflow_task_ready_scheduler_top_macros.svh =====
// Assertion macros shared by the checker files of the task ready scheduler.
// Each macro expands to one labelled concurrent assertion that is disabled while
// reset is held.
`ifndef DATAFLOW_TASK_READY_SCHEDULER_TOP_MACROS_SVH
`define DATAFLOW_TASK_READY_SCHEDULER_TOP_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define DTRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define DTRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dtrs_pkg.sv =====
`default_nettype none

package dtrs_pkg;

    // Default sizes of the task table and the buffer set.
    localparam int DEF_NUM_TASK_SLOTS = 8;
    localparam int DEF_NUM_BUFFERS    = 16;

    // Fixed field widths of the request and result channels.
    localparam int OP_W        = 2;
    localparam int TASK_IDX_W  = 3;
    localparam int MASK_W      = 16;
    localparam int DONE_W      = 8;
    localparam int CNT_TASK_W  = 4;
    localparam int CNT_BUF_W   = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CNT_TASK_W-1:0] RESET_ACTIVE_TASKS   = 4'd8;
    localparam logic [CNT_BUF_W-1:0]  RESET_ACTIVE_BUFFERS = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_TASK     = 2'd0,
        OP_MARK_FILLED   = 2'd1,
        OP_COMPLETE_TASK = 2'd2
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACTIVE_TASKS   = 1'd0,
        CFG_ACTIVE_BUFFERS = 1'd1
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_DONE,
        S_COLLECT,
        S_PICK
    } t_state;

    // Control broadcast from the sequencer to every cell of the task row.
    typedef struct packed {
        logic                  load;
        logic                  recompute;
        logic [TASK_IDX_W-1:0] task_index;
        logic [CNT_TASK_W-1:0] active_tasks;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/dtrs_cell.sv =====
`default_nettype none

// One task slot: holds the input and output buffer masks and the done bit of
// its task, and extends the needed, output-mask and pick chains of the row.
module dtrs_cell
    import dtrs_pkg::*;
#(
    parameter int NUM_BUFFERS = DEF_NUM_BUFFERS,
    parameter int IDX_W       = TASK_IDX_W,
    parameter int CELL_INDEX  = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cell_ctrl             i_ctrl,
    input  wire logic [NUM_BUFFERS-1:0] i_load_in_mask,
    input  wire logic [NUM_BUFFERS-1:0] i_load_out_mask,
    input  wire logic [NUM_BUFFERS-1:0] i_filled,
    input  wire logic [NUM_BUFFERS-1:0] i_needed,
    output logic      [NUM_BUFFERS-1:0] o_needed,
    input  wire logic [NUM_BUFFERS-1:0] i_omask,
    output logic      [NUM_BUFFERS-1:0] o_omask,
    input  wire logic                   i_found,
    output logic                        o_found,
    input  wire logic [IDX_W-1:0]       i_pick,
    output logic      [IDX_W-1:0]       o_pick,
    output logic                        o_done
);

    logic [NUM_BUFFERS-1:0] r_in_mask;
    logic [NUM_BUFFERS-1:0] r_out_mask;
    logic                   r_done;
    logic                   w_active;
    logic                   w_selected;
    logic                   w_live;
    logic                   w_ready;

    assign w_active   = 32'(i_ctrl.active_tasks) > CELL_INDEX;
    assign w_selected = 32'(i_ctrl.task_index) == CELL_INDEX;
    assign w_live     = w_active & ~r_done;
    assign w_ready    = w_live & ~|(r_in_mask & ~i_filled);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_mask  <= '0;
            r_out_mask <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_ctrl.load && w_selected) begin
                r_in_mask  <= i_load_in_mask;
                r_out_mask <= i_load_out_mask;
            end
            if (i_ctrl.recompute && w_active) begin
                r_done <= ~|(r_out_mask & ~i_filled);
            end
        end
    end

    assign o_omask  = i_omask | (w_selected ? r_out_mask : '0);
    assign o_needed = i_needed | (w_live ? r_in_mask : '0);
    assign o_found  = i_found | w_ready;
    assign o_pick   = (w_ready && !i_found) ? IDX_W'(CELL_INDEX) : i_pick;
    assign o_done   = r_done;

endmodule

`default_nettype wire

// ===== rtl/dataflow_task_ready_scheduler_top.sv =====
// The sequencer steps each accepted request through fill, done recomputation,
// collection and pick over the row of task cells, and takes no new request
// until the pick step has loaded the result register and returned to idle.
// Reset (synchronous, active low) clears the task table, the filled, needed and
// done bits and the result valid flag, and sets the counts to 8 tasks and 16 buffers.
`default_nettype none

module dataflow_task_ready_scheduler_top
    import dtrs_pkg::*;
#(
    parameter int NUM_TASK_SLOTS = DEF_NUM_TASK_SLOTS,
    parameter int NUM_BUFFERS    = DEF_NUM_BUFFERS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Request channel.
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [OP_W-1:0]        i_operation,
    input  wire logic [TASK_IDX_W-1:0]  i_task_index,
    input  wire logic [MASK_W-1:0]      i_input_mask,
    input  wire logic [MASK_W-1:0]      i_output_mask,
    // Result channel.
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic      [TASK_IDX_W-1:0]  o_next_task_index,
    output logic                        o_next_valid,
    output logic      [MASK_W-1:0]      o_filled_mask,
    output logic      [MASK_W-1:0]      o_needed_mask,
    output logic      [DONE_W-1:0]      o_done_mask,
    // Configuration write port.
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Width of a pick index inside the row; a single slot still needs one bit.
    localparam int IDX_W = (NUM_TASK_SLOTS > 1) ? $clog2(NUM_TASK_SLOTS) : 1;

    // Sequencer state and the captured request.
    t_state                  r_state;
    t_state                  n_state;
    t_op                     r_op;
    logic [TASK_IDX_W-1:0]   r_task;
    logic [NUM_BUFFERS-1:0]  r_in_mask;
    logic [NUM_BUFFERS-1:0]  r_out_mask;

    // Buffer state held outside the cells, since it is shared by every task.
    logic [NUM_BUFFERS-1:0]  r_filled;
    logic [NUM_BUFFERS-1:0]  n_filled;
    logic [NUM_BUFFERS-1:0]  r_needed;
    logic [NUM_BUFFERS-1:0]  n_needed;

    // Configuration registers.
    logic [CNT_TASK_W-1:0]   r_active_tasks;
    logic [CNT_BUF_W-1:0]    r_active_buffers;

    // Result register, which decouples the sequencer from a stalled consumer.
    logic                    r_out_valid;
    logic [TASK_IDX_W-1:0]   r_out_pick;
    logic                    r_out_found;
    logic [MASK_W-1:0]       r_out_filled;
    logic [MASK_W-1:0]       r_out_needed;
    logic [DONE_W-1:0]       r_out_done;

    logic                    w_in_accept;
    logic                    w_out_load;
    logic                    w_task_ok;
    t_cell_ctrl              w_ctrl;
    logic [NUM_BUFFERS-1:0]  w_examined;
    logic [NUM_TASK_SLOTS-1:0] w_done;

    // Chain signals running along the cell row; entry 0 is the head of the row.
    logic [NUM_BUFFERS-1:0]  w_needed [NUM_TASK_SLOTS+1];
    logic [NUM_BUFFERS-1:0]  w_omask  [NUM_TASK_SLOTS+1];
    logic                    w_found  [NUM_TASK_SLOTS+1];
    logic [IDX_W-1:0]        w_pick   [NUM_TASK_SLOTS+1];

    // The block takes a new request only when the sequencer is idle. A result still
    // waiting in the output register does not hold off the next request.
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;

    // A task index beyond the table turns load and complete into no operation.
    assign w_task_ok = 32'(r_task) < NUM_TASK_SLOTS;

    // Buffers below the active buffer count take part in garbage collection. The
    // comparison saturates the count at the number of buffers on its own.
    for (genvar b = 0; b < NUM_BUFFERS; b++) begin : g_examined
        assign w_examined[b] = 32'(r_active_buffers) > b;
    end

    assign w_needed[0] = '0;
    assign w_omask[0]  = '0;
    assign w_found[0]  = 1'b0;
    assign w_pick[0]   = '0;

    // The row of task cells. Each cell adds its contribution to the needed union,
    // offers its output mask when it is the addressed task, and passes the lowest
    // ready task found so far to its neighbour.
    for (genvar g = 0; g < NUM_TASK_SLOTS; g++) begin : g_cell
        dtrs_cell #(
            .NUM_BUFFERS (NUM_BUFFERS),
            .IDX_W       (IDX_W),
            .CELL_INDEX  (g)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctrl          (w_ctrl),
            .i_load_in_mask  (r_in_mask),
            .i_load_out_mask (r_out_mask),
            .i_filled        (r_filled),
            .i_needed        (w_needed[g]),
            .o_needed        (w_needed[g+1]),
            .i_omask         (w_omask[g]),
            .o_omask         (w_omask[g+1]),
            .i_found         (w_found[g]),
            .o_found         (w_found[g+1]),
            .i_pick          (w_pick[g]),
            .o_pick          (w_pick[g+1]),
            .o_done          (w_done[g])
        );
    end

    // State register of the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and the control of each step. The fill step loads a table entry
    // or sets filled bits; for a mark or completion the done step lets each active
    // cell recompute its done bit from the new filled bits; for a completion the
    // collect step rebuilds the needed bits and clears filled buffers no longer
    // needed; the pick step reads the row's answer into the free result register.
    always_comb begin
        n_state             = r_state;
        n_filled            = r_filled;
        n_needed            = r_needed;
        w_out_load          = 1'b0;
        w_ctrl.load         = 1'b0;
        w_ctrl.recompute    = 1'b0;
        w_ctrl.task_index   = r_task;
        w_ctrl.active_tasks = r_active_tasks;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                unique case (r_op)
                    OP_LOAD_TASK: begin
                        w_ctrl.load = w_task_ok;
                    end
                    OP_MARK_FILLED: begin
                        n_filled = r_filled | r_in_mask;
                    end
                    OP_COMPLETE_TASK: begin
                        if (w_task_ok) begin
                            n_filled = r_filled | w_omask[NUM_TASK_SLOTS];
                        end
                    end
                    default: ;
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                w_ctrl.recompute = (r_op == OP_MARK_FILLED) ||
                                   ((r_op == OP_COMPLETE_TASK) && w_task_ok);
                n_state = S_COLLECT;
            end
            S_COLLECT: begin
                if ((r_op == OP_COMPLETE_TASK) && w_task_ok) begin
                    n_needed = (r_needed & ~w_examined) | w_needed[NUM_TASK_SLOTS];
                    n_filled = r_filled & ~(w_examined & ~n_needed);
                end
                n_state = S_PICK;
            end
            S_PICK: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Buffer state, configuration and the result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled         <= '0;
            r_needed         <= '0;
            r_active_tasks   <= RESET_ACTIVE_TASKS;
            r_active_buffers <= RESET_ACTIVE_BUFFERS;
            r_out_valid      <= 1'b0;
        end else begin
            r_filled <= n_filled;
            r_needed <= n_needed;
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_ACTIVE_TASKS:   r_active_tasks   <= i_cfg_data[CNT_TASK_W-1:0];
                    CFG_ACTIVE_BUFFERS: r_active_buffers <= i_cfg_data[CNT_BUF_W-1:0];
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured request and result payload; these carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_op       <= t_op'(i_operation);
            r_task     <= i_task_index;
            r_in_mask  <= NUM_BUFFERS'(i_input_mask);
            r_out_mask <= NUM_BUFFERS'(i_output_mask);
        end
        if (w_out_load) begin
            r_out_pick   <= TASK_IDX_W'(w_pick[NUM_TASK_SLOTS]);
            r_out_found  <= w_found[NUM_TASK_SLOTS];
            r_out_filled <= MASK_W'(r_filled);
            r_out_needed <= MASK_W'(r_needed);
            r_out_done   <= DONE_W'(w_done);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_next_task_index = r_out_pick;
    assign o_next_valid      = r_out_found;
    assign o_filled_mask     = r_out_filled;
    assign o_needed_mask     = r_out_needed;
    assign o_done_mask       = r_out_done;

endmodule

`default_nettype wire

// ===== rtl/dtrs_checker.sv =====
`default_nettype none

`include "dataflow_task_ready_scheduler_top_macros.svh"

// Watches the ports of the scheduler top level.
module dtrs_checker
    import dtrs_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_stall,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_stall,
    input wire logic [TASK_IDX_W-1:0]  o_next_task_index,
    input wire logic                   o_next_valid,
    input wire logic [MASK_W-1:0]      o_filled_mask,
    input wire logic [MASK_W-1:0]      o_needed_mask,
    input wire logic [DONE_W-1:0]      o_done_mask
);

    // A stalled result stays offered and unchanged.
    `DTRS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_next_task_index) && $stable(o_next_valid)
            && $stable(o_filled_mask) && $stable(o_needed_mask) && $stable(o_done_mask),
        "stalled result changed")

    // An accepted request keeps the block busy in the following cycle.
    `DTRS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall, "request taken without busy cycle")

    // With no ready task the reported index is zero.
    `DTRS_ASSERT_IMP(a_no_pick_zero, i_clk, i_rst_n, o_out_valid && !o_next_valid,
        o_next_task_index == '0, "index set without a ready task")

    // The picked task is never one that is already done.
    `DTRS_ASSERT_IMP(a_pick_not_done, i_clk, i_rst_n, o_out_valid && o_next_valid,
        !o_done_mask[o_next_task_index], "picked task is marked done")

endmodule

bind dataflow_task_ready_scheduler_top dtrs_checker u_dtrs_checker (.*);

`default_nettype wire

// ===== test/dtrs_schedule_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the task ready scheduler, keeps its own copy of the
// task table and the buffer state, and checks every result in order.
module dtrs_schedule_checker
    import dtrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [OP_W-1:0]        i_operation,
    input  logic [TASK_IDX_W-1:0]  i_task_index,
    input  logic [MASK_W-1:0]      i_input_mask,
    input  logic [MASK_W-1:0]      i_output_mask,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [TASK_IDX_W-1:0]  i_next_task_index,
    input  logic                   i_next_valid,
    input  logic [MASK_W-1:0]      i_filled_mask,
    input  logic [MASK_W-1:0]      i_needed_mask,
    input  logic [DONE_W-1:0]      i_done_mask,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    typedef struct packed {
        logic [TASK_IDX_W-1:0] next_index;
        logic                  next_valid;
        logic [MASK_W-1:0]     filled;
        logic [MASK_W-1:0]     needed;
        logic [DONE_W-1:0]     done;
    } t_sched_view;

    logic [MASK_W-1:0]     reads_of  [DEF_NUM_TASK_SLOTS];
    logic [MASK_W-1:0]     writes_of [DEF_NUM_TASK_SLOTS];
    logic [MASK_W-1:0]     filled_bits;
    logic [MASK_W-1:0]     needed_bits;
    logic [DONE_W-1:0]     done_bits;
    logic [CNT_TASK_W-1:0] task_count_reg;
    logic [CNT_BUF_W-1:0]  buffer_count_reg;
    t_sched_view           expected_views [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic int live_tasks();
        return (task_count_reg > DEF_NUM_TASK_SLOTS) ? DEF_NUM_TASK_SLOTS : int'(task_count_reg);
    endfunction

    // Only the active entries have their done bit refreshed.
    task automatic refresh_done();
        for (int i = 0; i < live_tasks(); i++) begin
            done_bits[i] = ((writes_of[i] & ~filled_bits) == '0);
        end
    endtask

    task automatic advance_schedule(input logic [OP_W-1:0] op,
                                    input logic [TASK_IDX_W-1:0] idx,
                                    input logic [MASK_W-1:0] reads,
                                    input logic [MASK_W-1:0] writes,
                                    output t_sched_view view);
        int                nb;
        logic [MASK_W-1:0] examined;
        logic [MASK_W-1:0] need;
        logic              found;
        view = '0;
        case (op)
            OP_LOAD_TASK: begin
                reads_of[idx]  = reads;
                writes_of[idx] = writes;
            end
            OP_MARK_FILLED: begin
                filled_bits |= reads;
                refresh_done();
            end
            OP_COMPLETE_TASK: begin
                filled_bits |= writes_of[idx];
                refresh_done();
                // Garbage collection: buffers beyond the active count keep their
                // needed bits and are never freed.
                nb = (buffer_count_reg > DEF_NUM_BUFFERS) ? DEF_NUM_BUFFERS
                                                          : int'(buffer_count_reg);
                examined = (nb >= MASK_W) ? '1 : ((MASK_W'(1) << nb) - MASK_W'(1));
                need = needed_bits & ~examined;
                for (int i = 0; i < live_tasks(); i++) begin
                    if (!done_bits[i]) need |= reads_of[i];
                end
                needed_bits = need;
                filled_bits &= ~(examined & ~need);
            end
            default: begin
            end
        endcase
        found = 1'b0;
        for (int i = 0; i < live_tasks(); i++) begin
            if (!found && !done_bits[i] && ((reads_of[i] & ~filled_bits) == '0)) begin
                found           = 1'b1;
                view.next_index = TASK_IDX_W'(i);
                view.next_valid = 1'b1;
            end
        end
        view.filled = filled_bits;
        view.needed = needed_bits;
        view.done   = done_bits;
    endtask

    task automatic report(input string field, input int want, input int got);
        $display("%0t: %s differs, expected 0x%0h, got 0x%0h", $time, field, want, got);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        t_sched_view want;
        t_sched_view got;
        if (!i_rst_n) begin
            for (int i = 0; i < DEF_NUM_TASK_SLOTS; i++) begin
                reads_of[i]  = '0;
                writes_of[i] = '0;
            end
            filled_bits      = '0;
            needed_bits      = '0;
            done_bits        = '0;
            task_count_reg   = RESET_ACTIVE_TASKS;
            buffer_count_reg = RESET_ACTIVE_BUFFERS;
            expected_views.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_views.size() == 0) begin
                    $display("%0t: result with no request outstanding, expected none, got %0d",
                             $time, i_next_task_index);
                    o_mismatches++;
                end else begin
                    want = expected_views.pop_front();
                    got  = '{i_next_task_index, i_next_valid, i_filled_mask,
                             i_needed_mask, i_done_mask};
                    if (got.next_index !== want.next_index)
                        report("next_task_index", want.next_index, got.next_index);
                    if (got.next_valid !== want.next_valid)
                        report("next_valid", want.next_valid, got.next_valid);
                    if (got.filled !== want.filled)
                        report("filled_mask", want.filled, got.filled);
                    if (got.needed !== want.needed)
                        report("needed_mask", want.needed, got.needed);
                    if (got.done !== want.done)
                        report("done_mask", want.done, got.done);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_schedule(i_operation, i_task_index, i_input_mask, i_output_mask, want);
                expected_views.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE_TASKS:   task_count_reg   = i_cfg_data[CNT_TASK_W-1:0];
                    CFG_ACTIVE_BUFFERS: buffer_count_reg = i_cfg_data[CNT_BUF_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        o_outstanding = expected_views.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

// Top of the scheduler testbench. This module only makes stimulus and gives the
// verdict; all prediction and comparison lives in the checker instantiated below.
module testbench;
    import dtrs_pkg::*;

    // The operation field is two bits wide, so the fourth code must be exercised
    // as well; the block treats it as a request that changes nothing.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int MAX_IDLE    = 11;
    localparam int LONG_HOLD   = 80;
    localparam int PHASE_ITEMS = 230;
    localparam int NUM_PHASES  = 8;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [OP_W-1:0]        op;
    logic [TASK_IDX_W-1:0]  task_index;
    logic [MASK_W-1:0]      input_mask;
    logic [MASK_W-1:0]      output_mask;
    logic                   out_valid;
    logic                   out_stall;
    logic [TASK_IDX_W-1:0]  next_task_index;
    logic                   next_valid;
    logic [MASK_W-1:0]      filled_mask;
    logic [MASK_W-1:0]      needed_mask;
    logic [DONE_W-1:0]      done_mask;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int requests_sent;

    // When set, neither side inserts random idle cycles, so the block runs at full rate.
    bit calm_phase;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    dataflow_task_ready_scheduler_top dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_operation       (op),
        .i_task_index      (task_index),
        .i_input_mask      (input_mask),
        .i_output_mask     (output_mask),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_next_task_index (next_task_index),
        .o_next_valid      (next_valid),
        .o_filled_mask     (filled_mask),
        .o_needed_mask     (needed_mask),
        .o_done_mask       (done_mask),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    dtrs_schedule_checker checker_inst (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_operation       (op),
        .i_task_index      (task_index),
        .i_input_mask      (input_mask),
        .i_output_mask     (output_mask),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_next_task_index (next_task_index),
        .i_next_valid      (next_valid),
        .i_filled_mask     (filled_mask),
        .i_needed_mask     (needed_mask),
        .i_done_mask       (done_mask),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    // Offers one request after a random number of idle cycles and returns at the
    // rising edge where the block takes it. Every signal is changed on the
    // falling edge, and only once per edge, so the block never sees a race.
    task automatic send_request(input logic [OP_W-1:0] req_op,
                                input logic [TASK_IDX_W-1:0] req_task,
                                input logic [MASK_W-1:0] req_reads,
                                input logic [MASK_W-1:0] req_writes);
        int gap;
        gap = calm_phase ? 0 : $urandom_range(0, MAX_IDLE);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        op          <= req_op;
        task_index  <= req_task;
        input_mask  <= req_reads;
        output_mask <= req_writes;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent++;
    endtask

    // Withdraws the request line and waits until every outstanding result has
    // been taken. The checker's count is read on the falling edge, by which time
    // the last accepted request has been booked.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    // Writes both count registers; only called while the block is idle.
    task automatic configure(input logic [CFG_DATA_W-1:0] tasks,
                             input logic [CFG_DATA_W-1:0] buffers);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACTIVE_TASKS;
        cfg_data  <= tasks;
        @(negedge clk);
        cfg_index <= CFG_ACTIVE_BUFFERS;
        cfg_data  <= buffers;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly sparse masks of one to three buffers, so that tasks genuinely
    // depend on one another, with the odd empty, full or dense mask mixed in.
    function automatic logic [MASK_W-1:0] buffer_mask();
        int                kind;
        logic [MASK_W-1:0] m;
        kind = $urandom_range(0, 9);
        m    = '0;
        case (kind)
            0: m = '0;
            1: m = MASK_W'($urandom);
            2: m = '1;
            default: begin
                repeat ($urandom_range(1, 3)) m[$urandom_range(0, MASK_W - 1)] = 1'b1;
            end
        endcase
        return m;
    endfunction

    // One small workflow: a table of tasks, each usually reading what the
    // previous one writes, followed by a random run of fills, completions and
    // the occasional stray request.
    task automatic run_workflow();
        int                entries;
        int                steps;
        int                pick;
        logic [MASK_W-1:0] prev_writes;
        logic [MASK_W-1:0] reads;
        logic [MASK_W-1:0] writes;
        entries     = $urandom_range(1, DEF_NUM_TASK_SLOTS);
        prev_writes = '0;
        for (int t = 0; t < entries; t++) begin
            reads       = ($urandom_range(0, 2) == 0) ? buffer_mask() : prev_writes;
            writes      = buffer_mask();
            prev_writes = writes;
            send_request(OP_LOAD_TASK, TASK_IDX_W'(t), reads, writes);
        end
        // Now and then the sender waits for every result before carrying on.
        if ($urandom_range(0, 3) == 0) drain();
        steps = $urandom_range(5, 20);
        repeat (steps) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3)
                send_request(OP_COMPLETE_TASK, TASK_IDX_W'($urandom_range(0, entries - 1)),
                             MASK_W'($urandom), MASK_W'($urandom));
            else if (pick == 4)
                send_request(OP_COMPLETE_TASK, TASK_IDX_W'($urandom), buffer_mask(),
                             buffer_mask());
            else if (pick <= 7)
                send_request(OP_MARK_FILLED, TASK_IDX_W'($urandom), buffer_mask(),
                             MASK_W'($urandom));
            else if (pick == 8)
                send_request(OP_UNUSED, TASK_IDX_W'($urandom), MASK_W'($urandom),
                             MASK_W'($urandom));
            else
                send_request(OP_LOAD_TASK, TASK_IDX_W'($urandom), buffer_mask(),
                             buffer_mask());
        end
    endtask

    // Receiver: waits a random number of cycles before taking each result. Twice
    // in the run it holds off for a long stretch so that the block backs up and
    // stalls its request side while the sender keeps offering.
    initial begin : receiver
        int hold;
        int taken;
        out_stall = 1'b0;
        taken     = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (taken == 300 || taken == 1100)
                hold = LONG_HOLD;
            else
                hold = calm_phase ? 0 : $urandom_range(0, MAX_IDLE);
            repeat (hold) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
            taken++;
        end
    end

    // Sender and verdict.
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] task_settings   [NUM_PHASES];
        logic [CFG_DATA_W-1:0] buffer_settings [NUM_PHASES];
        int                    phase_end;

        // Count settings for the random phases: the extremes first, including
        // out-of-range values that must saturate and a task count with its
        // unused upper data bit set.
        task_settings   = '{5'd24, 5'd0, 5'd15, 5'd1, 5'd8, 5'd0, 5'd3, 5'd8};
        buffer_settings = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd0, 5'd16, 5'd7, 5'd16};

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_LOAD_TASK;
        task_index    = '0;
        input_mask    = '0;
        output_mask   = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_ACTIVE_TASKS;
        cfg_data      = '0;
        calm_phase    = 1'b0;
        requests_sent = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, under the counts set by reset. A stray operation code,
        // empty and full masks, a short chain of tasks and their completion.
        send_request(OP_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF);
        send_request(OP_LOAD_TASK, 3'd0, 16'h0000, 16'h0000);
        send_request(OP_LOAD_TASK, 3'd7, 16'hFFFF, 16'hFFFF);
        send_request(OP_LOAD_TASK, 3'd1, 16'h0001, 16'h0002);
        send_request(OP_LOAD_TASK, 3'd2, 16'h0002, 16'h0004);
        send_request(OP_MARK_FILLED, 3'd0, 16'h0000, 16'h0000);
        send_request(OP_MARK_FILLED, 3'd5, 16'h0001, 16'hFFFF);
        send_request(OP_COMPLETE_TASK, 3'd1, 16'h0000, 16'h0000);
        send_request(OP_COMPLETE_TASK, 3'd2, 16'h0000, 16'h0000);
        send_request(OP_COMPLETE_TASK, 3'd0, 16'h0000, 16'h0000);
        send_request(OP_LOAD_TASK, 3'd3, 16'h8000, 16'h8000);
        send_request(OP_MARK_FILLED, 3'd0, 16'hFFFF, 16'h0000);
        send_request(OP_COMPLETE_TASK, 3'd7, 16'h0000, 16'h0000);
        send_request(OP_COMPLETE_TASK, 3'd3, 16'h0000, 16'h0000);

        // No active tasks and no collected buffers: nothing can be picked.
        drain();
        configure(5'd0, 5'd0);
        send_request(OP_LOAD_TASK, 3'd0, 16'h0003, 16'h0004);
        send_request(OP_MARK_FILLED, 3'd0, 16'h0003, 16'h0000);
        send_request(OP_COMPLETE_TASK, 3'd0, 16'h0000, 16'h0000);

        // Both counts beyond the table size, which must saturate.
        drain();
        configure(5'd15, 5'd31);
        send_request(OP_MARK_FILLED, 3'd0, 16'h0030, 16'h0000);
        send_request(OP_COMPLETE_TASK, 3'd7, 16'h0000, 16'h0000);

        // Two tasks and four buffers: needed bits above the collected range
        // survive, and the inactive tasks keep their done bits.
        drain();
        configure(5'd2, 5'd4);
        send_request(OP_LOAD_TASK, 3'd1, 16'h0010, 16'h0020);
        send_request(OP_COMPLETE_TASK, 3'd1, 16'h0000, 16'h0000);
        send_request(OP_MARK_FILLED, 3'd0, 16'h00F0, 16'h0000);
        send_request(OP_COMPLETE_TASK, 3'd0, 16'h0000, 16'h0000);

        // Random phases, each under its own counts. Registers are only written
        // once the block has returned every result of the phase before.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p < 4)
                configure(task_settings[p], buffer_settings[p]);
            else if ($urandom_range(0, 1) == 0)
                configure(task_settings[p], buffer_settings[p]);
            else
                configure(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 31)));
            calm_phase = (p == 2) || ($urandom_range(0, 3) == 0);
            phase_end  = requests_sent + PHASE_ITEMS;
            while (requests_sent < phase_end) run_workflow();
        end

        drain();
        calm_phase = 1'b0;
        // Wait before the verdict so that any stray result is still seen.
        repeat (20) @(negedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
